// File: src/confidence_weighted_window_average_core_macros.svh
// ----------------------------------------------------------------------------
// Confidence weighted window average: assertion macros
// Immediate-consequence and next-cycle property forms on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef CONFIDENCE_WEIGHTED_WINDOW_AVERAGE_CORE_MACROS_SVH
`define CONFIDENCE_WEIGHTED_WINDOW_AVERAGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CWWA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cwwa: property violated");
`define CWWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cwwa: property violated");
`else
`define CWWA_ASSERT_IMPL(lbl, ante, cons)
`define CWWA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/cwwa_pkg.sv
// ----------------------------------------------------------------------------
// Confidence weighted window average: package
// Widths, request/result payloads and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwwa_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int CFG_W      = 5;
  localparam int DATA_W     = 16;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W      = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int SC_W       = DATA_W + LEN_W;
  localparam int SP_W       = 2 * DATA_W + LEN_W;
  localparam int ENTRY_W    = 3 * DATA_W;
  localparam int LANES      = 3;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int LEN_RST    = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;

  typedef struct packed {
    logic [DATA_W-1:0] confidence;
    logic [DATA_W-1:0] obj_width;
    logic [DATA_W-1:0] obj_height;
    logic              sample_valid;
  } cwwa_in_t;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] avg_confidence;
    logic [DATA_W-1:0] avg_width;
    logic [DATA_W-1:0] avg_height;
    logic              window_empty;
  } cwwa_out_t;

  typedef struct packed {
    logic cap;
    logic wr;
    logic rd_start;
    logic rd_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } cwwa_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic rd_last;
    logic pipe_busy;
  } cwwa_sts_t;

endpackage

`default_nettype wire

// File: src/cwwa_ram.sv
// ----------------------------------------------------------------------------
// Confidence weighted window average: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwwa_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/cwwa_datapath.sv
// ----------------------------------------------------------------------------
// Confidence weighted window average: datapath
// Window bookkeeping, entry store, product/accumulate pipeline, three
// restoring divider lanes and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwwa_datapath import cwwa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  cwwa_in_t         in_req_i,
  input  cwwa_cmd_t        cmd_i,
  output cwwa_sts_t        sts_o,
  output cwwa_out_t        out_rsp_o
);

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p,
                                                 input logic [LEN_W-1:0]  n);
    logic [LEN_W:0] s;
    s = (LEN_W+1)'(p) + (LEN_W+1)'(1);
    if (s == (LEN_W+1)'(n)) begin
      s = '0;
    end
    return SLOT_W'(s);
  endfunction

  logic [LEN_W-1:0]    len_q, fill_q, rd_cnt_q;
  logic [SLOT_W-1:0]   oldest_q, rd_ptr_q;
  logic                rv_q, pv_q;
  cwwa_in_t            in_q;
  cwwa_out_t           rsp_q, rsp_d;
  logic [DATA_W-1:0]   pc_q;
  logic [2*DATA_W-1:0] prod_q [LANES];
  logic [SC_W-1:0]     sc_q;
  logic [SP_W-1:0]     num_q  [LANES];
  logic [SC_W-1:0]     rem_q  [LANES];
  logic [DATA_W-1:0]   quo_q  [LANES];

  logic [CMP_W-1:0]    cfg_cmp;
  logic [LEN_W-1:0]    len_d;
  logic                full;
  logic [LEN_W:0]      wsum;
  logic [SLOT_W-1:0]   wr_slot;
  logic                wr_en;
  logic [ENTRY_W-1:0]  rd_data;
  logic [DATA_W-1:0]   opnd  [LANES];
  logic [SC_W:0]       trial [LANES];
  logic                ge    [LANES];
  logic [SC_W-1:0]     rem_d [LANES];

  always_comb begin
    cfg_cmp = CMP_W'(cfg_wdata_i);
    if (cfg_cmp == '0) begin
      len_d = LEN_W'(1);
    end else if (cfg_cmp > CMP_W'(WINDOW_MAX)) begin
      len_d = LEN_W'(WINDOW_MAX);
    end else begin
      len_d = LEN_W'(cfg_cmp);
    end
  end

  always_comb begin
    full = (fill_q == len_q);
    wsum = (LEN_W+1)'(oldest_q) + (LEN_W+1)'(fill_q);
    if (wsum >= (LEN_W+1)'(len_q)) begin
      wsum = wsum - (LEN_W+1)'(len_q);
    end
    wr_slot = full ? oldest_q : SLOT_W'(wsum);
    wr_en   = cmd_i.wr && in_q.sample_valid;
  end

  cwwa_ram #(
    .Width (ENTRY_W),
    .Depth (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_slot),
    .wdata_i ({in_q.confidence, in_q.obj_width, in_q.obj_height}),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    opnd[0] = rd_data[ENTRY_W-1 -: DATA_W];
    opnd[1] = rd_data[2*DATA_W-1 -: DATA_W];
    opnd[2] = rd_data[DATA_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem_q[i], quo_q[i][DATA_W-1]};
      ge[i]    = (trial[i] >= {1'b0, sc_q});
      rem_d[i] = ge[i] ? SC_W'(trial[i] - {1'b0, sc_q}) : trial[i][SC_W-1:0];
    end
  end

  always_comb begin
    rsp_d.accepted       = in_q.sample_valid;
    rsp_d.window_empty   = (sc_q == '0);
    rsp_d.avg_confidence = rsp_d.window_empty ? '0 : quo_q[0];
    rsp_d.avg_width      = rsp_d.window_empty ? '0 : quo_q[1];
    rsp_d.avg_height     = rsp_d.window_empty ? '0 : quo_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_W'(LEN_RST);
      fill_q   <= '0;
      oldest_q <= '0;
      rd_ptr_q <= '0;
      rd_cnt_q <= '0;
      rv_q     <= 1'b0;
      pv_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q    <= len_d;
        fill_q   <= '0;
        oldest_q <= '0;
      end else if (wr_en) begin
        if (full) begin
          oldest_q <= wrap_inc(oldest_q, len_q);
        end else begin
          fill_q <= fill_q + LEN_W'(1);
        end
      end
      if (cmd_i.rd_start) begin
        rd_ptr_q <= oldest_q;
        rd_cnt_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q, len_q);
        rd_cnt_q <= rd_cnt_q + LEN_W'(1);
      end
      rv_q <= cmd_i.rd_en;
      pv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      in_q <= in_req_i;
      sc_q <= '0;
      for (int i = 0; i < LANES; i++) begin
        num_q[i] <= '0;
      end
    end else if (pv_q) begin
      sc_q <= sc_q + SC_W'(pc_q);
      for (int i = 0; i < LANES; i++) begin
        num_q[i] <= num_q[i] + SP_W'(prod_q[i]);
      end
    end
    if (rv_q) begin
      pc_q <= opnd[0];
      for (int i = 0; i < LANES; i++) begin
        prod_q[i] <= opnd[0] * opnd[i];
      end
    end
    if (cmd_i.div_start) begin
      for (int i = 0; i < LANES; i++) begin
        rem_q[i] <= num_q[i][SP_W-1:DATA_W];
        quo_q[i] <= num_q[i][DATA_W-1:0];
      end
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= {quo_q[i][DATA_W-2:0], ge[i]};
      end
    end
    if (cmd_i.out_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.rd_last   = (rd_cnt_q == fill_q - LEN_W'(1));
  assign sts_o.pipe_busy = rv_q || pv_q;
  assign out_rsp_o       = rsp_q;

endmodule

`default_nettype wire

// File: src/cwwa_ctrl.sv
// ----------------------------------------------------------------------------
// Confidence weighted window average: controller
// Sequences store, window read, divide and result hand-off per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwwa_ctrl import cwwa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  cwwa_sts_t sts_i,
  output cwwa_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_START,
    S_READ,
    S_DRAIN,
    S_DIVI,
    S_DIV,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.cap       = in_valid_i;
      S_WRITE: cmd_o.wr        = 1'b1;
      S_START: cmd_o.rd_start  = 1'b1;
      S_READ:  cmd_o.rd_en     = 1'b1;
      S_DRAIN: cmd_o           = '0;
      S_DIVI:  cmd_o.div_start = 1'b1;
      S_DIV:   cmd_o.div_step  = 1'b1;
      S_DONE:  cmd_o.out_load  = !out_valid_q || !out_stall_i;
      default: cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: state_q <= S_START;
        S_START: state_q <= sts_i.fill_zero ? S_DRAIN : S_READ;
        S_READ: begin
          if (sts_i.rd_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            state_q <= S_DIVI;
          end
        end
        S_DIVI: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + DCNT_W'(1);
          end
        end
        S_DONE: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/confidence_weighted_window_average_core.sv
// Per request: store a valid sample, then one RAM read per entry in the window
// (none when the window holds no entries), then a 16-step restoring divide
// in three parallel lanes. A new request is taken only after the previous
// result is loaded into the result register, which frees the input side
// while a result waits.
// Reset clears the window and sets length 16.
// ----------------------------------------------------------------------------
// Confidence weighted window average core
// Sliding window of observations with confidence-weighted averages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "confidence_weighted_window_average_core_macros.svh"

module confidence_weighted_window_average_core import cwwa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cwwa_in_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cwwa_out_t        out_rsp_o
);

  cwwa_cmd_t cmd;
  cwwa_sts_t sts;
  logic      avg_zero;

  cwwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cwwa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

  assign avg_zero = (out_rsp_o.avg_confidence == '0) && (out_rsp_o.avg_width == '0) &&
                    (out_rsp_o.avg_height == '0);

  `CWWA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `CWWA_ASSERT_IMPL(a_empty_zero, out_valid_o && out_rsp_o.window_empty, avg_zero)
  `CWWA_ASSERT_IMPL(a_load_busy, cmd.out_load, in_stall_o)
  `CWWA_ASSERT_IMPL(a_read_nonempty, cmd.rd_en, !sts.fill_zero)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Confidence weighted window average: testbench
// Drives observation requests through a directed table and then randomized
// phases at several window lengths, with random idling on both sides and one
// long result stall. A behavioral window model predicts every result; the
// checker compares each field against the oldest pending expectation.
// ----------------------------------------------------------------------------

module tb_top;
  import cwwa_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 54;
  localparam int LONG_HOLD = 400;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] len;
    cwwa_in_t         obs;
    logic             typed;
    cwwa_out_t        want;
  } vec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  cwwa_in_t         req = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  cwwa_out_t        rsp;

  cwwa_out_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  logic [DATA_W-1:0] win_conf [WINDOW_MAX];
  logic [DATA_W-1:0] win_width [WINDOW_MAX];
  logic [DATA_W-1:0] win_height [WINDOW_MAX];
  int unsigned       win_fill = 0;
  int unsigned       win_head = 0;
  logic [CFG_W-1:0]  win_len_reg = CFG_W'(LEN_RST);

  vec_t directed_vecs [0:22] = '{
    '{1'b0, 5'd0, '{16'h0000, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{1'b0, 5'd0, '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1},
      1'b1, '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{1'b0, 5'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
      1'b1, '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
    '{1'b0, 5'd0, '{16'hFFFF, 16'h1234, 16'h4321, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h0001, 16'h0000, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{1'b0, 5'd0, '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b1}, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h5555, 16'hAAAA, 16'h5555, 1'b1}, 1'b0, '0},
    '{1'b1, 5'd1, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h8000, 16'h1234, 16'h4321, 1'b1},
      1'b1, '{1'b1, 16'h8000, 16'h1234, 16'h4321, 1'b0}},
    '{1'b0, 5'd0, '{16'h0000, 16'hABCD, 16'hDCBA, 1'b1},
      1'b1, '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{1'b0, 5'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
      1'b1, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{1'b1, 5'd0, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{16'hFFFF, 16'h00FF, 16'hFF00, 1'b1},
      1'b1, '{1'b1, 16'hFFFF, 16'h00FF, 16'hFF00, 1'b0}},
    '{1'b0, 5'd0, '{16'h0007, 16'h8001, 16'h7FFE, 1'b1},
      1'b1, '{1'b1, 16'h0007, 16'h8001, 16'h7FFE, 1'b0}},
    '{1'b1, 5'd31, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h1234, 16'h1234, 16'h1234, 1'b0},
      1'b1, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{1'b0, 5'd0, '{16'hFFFF, 16'h0000, 16'h0000, 1'b1},
      1'b1, '{1'b1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 5'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{1'b1, 5'd2, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h0100, 16'h0200, 16'h0300, 1'b1}, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h0300, 16'h0400, 16'h0500, 1'b1}, 1'b0, '0},
    '{1'b0, 5'd0, '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{1'b1, 5'd16, '0, 1'b0, '0}
  };

  int phase_len [PHASES] = '{16, 1, 0, 31, 17, 2, 8, 15, 3};

  confidence_weighted_window_average_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp)
  );

  always #6 clk = ~clk;

  function automatic cwwa_out_t predict_avgs(input cwwa_in_t r);
    int unsigned len, slot, k, s;
    logic [63:0] sc, scc, scw, sch, ck;
    cwwa_out_t o;
    len = (win_len_reg == 0) ? 1 :
          ((win_len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_len_reg));
    if (win_fill > len) win_fill = len;
    if (win_head >= len) win_head = 0;
    if (r.sample_valid) begin
      if (win_fill < len) begin
        slot = (win_head + win_fill) % len;
        win_fill++;
      end else begin
        slot = win_head;
        win_head = (win_head + 1) % len;
      end
      win_conf[slot] = r.confidence;
      win_width[slot] = r.obj_width;
      win_height[slot] = r.obj_height;
    end
    sc = '0;
    scc = '0;
    scw = '0;
    sch = '0;
    for (k = 0; k < win_fill; k++) begin
      s = (win_head + k) % len;
      ck = 64'(win_conf[s]);
      sc += ck;
      scc += ck * ck;
      scw += ck * 64'(win_width[s]);
      sch += ck * 64'(win_height[s]);
    end
    o = '0;
    o.accepted = r.sample_valid;
    o.window_empty = (sc == 0);
    if (sc != 0) begin
      o.avg_confidence = DATA_W'(scc / sc);
      o.avg_width = DATA_W'(scw / sc);
      o.avg_height = DATA_W'(sch / sc);
    end
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] rand_field();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return DATA_W'($urandom_range(255));
    return DATA_W'($urandom);
  endfunction

  function automatic cwwa_in_t rand_obs();
    cwwa_in_t r;
    r.confidence = ($urandom_range(99) < 15) ? '0 : rand_field();
    r.obj_width = rand_field();
    r.obj_height = rand_field();
    r.sample_valid = ($urandom_range(99) < 85);
    return r;
  endfunction

  task automatic send_obs(input cwwa_in_t r, input logic typed, input cwwa_out_t want);
    cwwa_out_t predicted;
    if (!(requests_sent >= 300 && requests_sent < 380) && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_avgs(r);
    exp_buf[exp_wr % EXP_DEPTH] = typed ? want : predicted;
    exp_wr++;
    requests_sent++;
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    req_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len_reg = v;
    win_fill = 0;
    win_head = 0;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    cwwa_out_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result expected none got %h", $time, rsp);
        errors++;
      end else begin
        want = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        check_field("accepted", DATA_W'(want.accepted), DATA_W'(rsp.accepted));
        check_field("avg_confidence", want.avg_confidence, rsp.avg_confidence);
        check_field("avg_width", want.avg_width, rsp.avg_width);
        check_field("avg_height", want.avg_height, rsp.avg_height);
        check_field("window_empty", DATA_W'(want.window_empty), DATA_W'(rsp.window_empty));
      end
      results_seen++;
    end
    // hold off once for a long stretch so the core backs up into its input
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (results_seen == 120 && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !(results_seen >= 250 && results_seen < 330) && ($urandom_range(99) < 8);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int p, n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_vecs[i]) begin
      if (directed_vecs[i].is_cfg) write_length(directed_vecs[i].len);
      else send_obs(directed_vecs[i].obs, directed_vecs[i].typed, directed_vecs[i].want);
    end
    phase_len[PHASES-1] = $urandom_range(31);
    for (p = 0; p < PHASES; p++) begin
      write_length(CFG_W'(phase_len[p]));
      for (n = 0; n < PHASE_ITEMS; n++) send_obs(rand_obs(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
